### design/csbp_pkg.sv
// ----------------------------------------------------------------------------
// Call stack block profiler package
// Item types and event and status codes shared by the profiler design.
// ----------------------------------------------------------------------------
package csbp_pkg;

  localparam int KIND_W  = 2;
  localparam int LIB_W   = 4;
  localparam int FUN_W   = 10;
  localparam int COUNT_W = 32;
  localparam int STATUS_W = 2;

  // Event kinds carried by an input transfer.
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXIT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_START = 2'd3;

  // Status codes carried by a result transfer.
  localparam logic [STATUS_W-1:0] STATUS_REPORT    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LIB_W-1:0]  lib_id;
    logic [FUN_W-1:0]  fun_id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LIB_W-1:0]    report_lib;
    logic [FUN_W-1:0]    report_fun;
    logic [COUNT_W-1:0]  block_total;
  } out_item_t;

endpackage

### design/call_stack_block_profiler.sv
// ----------------------------------------------------------------------------
// Call stack block profiler
// Attributes basic block ticks to functions through a call stack and a
// per-function counter table held in synchronous memory.
// ----------------------------------------------------------------------------
// Usage: events arrive on the in_ channel (tick, function entry, function
// exit, program start); exit reports and stack errors leave on the out_
// channel. Both channels use valid and stall, and a transfer happens on a
// rising edge with valid high and stall low.
// Steps per input transfer, from acceptance to the next acceptance:
//   tick, overflow, underflow and an entry on an empty stack: the idle state alone.
//   entry on a non-empty stack: stack read, then a table read and
//   write-back of the caller's counter.
//   exit: table read, then write-back of zero; the report is loaded into
//   the output register in the exit state and then shows on out_valid.
//   start: the whole table is cleared, one table entry cleared per cycle.
// Event handling is bounded by the single table memory: one read, then one write.
// After reset the block sweeps the table to zero with in_stall high.
// A result waits in the output register while out_stall is high; a new
// event is taken once that register is free or is being emptied.
// ----------------------------------------------------------------------------
module call_stack_block_profiler
  import csbp_pkg::*;
#(
  parameter int NUM_LIBS    = 16,
  parameter int NUM_FUNCS   = 1024,
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int TABLE_SIZE = NUM_LIBS * NUM_FUNCS;
  localparam int TIDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int SADDR_W    = $clog2(STACK_DEPTH);
  localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
  localparam int SENTRY_W   = LIB_W + FUN_W;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_STACK = 3'd2;
  localparam logic [2:0] S_TABLE = 3'd3;
  localparam logic [2:0] S_EXIT  = 3'd4;

  localparam logic [COUNT_W-1:0] SAT_MAX = '1;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? SAT_MAX : s[COUNT_W-1:0];
  endfunction

  function automatic logic in_table(input logic [LIB_W-1:0] lib,
                                    input logic [FUN_W-1:0] fun);
    return (int'(lib) < NUM_LIBS) && (int'(fun) < NUM_FUNCS);
  endfunction

  function automatic logic [TIDX_W-1:0] table_index(input logic [LIB_W-1:0] lib,
                                                    input logic [FUN_W-1:0] fun);
    logic [31:0] idx;
    idx = 32'(lib) * 32'(NUM_FUNCS) + 32'(fun);
    return idx[TIDX_W-1:0];
  endfunction

  // Control and datapath registers.
  logic [2:0]          state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [COUNT_W-1:0]  running_r, running_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [TIDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                start_pend_r, start_pend_nxt;
  logic [TIDX_W-1:0]   tidx_r, tidx_nxt;
  logic                tin_r, tin_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Memory ports.
  logic [COUNT_W-1:0]  table_mem [TABLE_SIZE];
  logic [COUNT_W-1:0]  tbl_rdata_r;
  logic                tbl_we, tbl_re;
  logic [TIDX_W-1:0]   tbl_waddr, tbl_raddr;
  logic [COUNT_W-1:0]  tbl_wdata;

  logic [SENTRY_W-1:0] stack_mem [STACK_DEPTH];
  logic [SENTRY_W-1:0] stk_rdata_r;
  logic                stk_we, stk_re;
  logic [SADDR_W-1:0]  stk_waddr, stk_raddr;
  logic [SENTRY_W-1:0] stk_wdata;

  logic                in_fire;
  logic                out_free;
  logic [LIB_W-1:0]    top_lib;
  logic [FUN_W-1:0]    top_fun;
  logic [COUNT_W-1:0]  exit_base;

  // A new event is taken only while idle and the result register can take
  // whatever the event may produce.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign top_lib   = stk_rdata_r[SENTRY_W-1:FUN_W];
  assign top_fun   = stk_rdata_r[FUN_W-1:0];
  assign exit_base = tin_r ? tbl_rdata_r : '0;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    running_nxt    = running_r;
    depth_nxt      = depth_r;
    clr_cnt_nxt    = clr_cnt_r;
    start_pend_nxt = start_pend_r;
    tidx_nxt       = tidx_r;
    tin_nxt        = tin_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    tbl_we    = 1'b0;
    tbl_waddr = tidx_r;
    tbl_wdata = '0;
    tbl_re    = 1'b0;
    tbl_raddr = tidx_r;
    stk_we    = 1'b0;
    stk_waddr = depth_r[SADDR_W-1:0];
    stk_wdata = {item_r.lib_id, item_r.fun_id};
    stk_re    = 1'b0;
    stk_raddr = SADDR_W'(depth_r - DEPTH_W'(1));

    unique case (state_r)
      S_CLEAR: begin
        // One table entry is zeroed per cycle; a pending start then pushes
        // its function onto the now empty stack.
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt_r;
        if (clr_cnt_r == TIDX_W'(TABLE_SIZE - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
          if (start_pend_r) begin
            stk_we         = 1'b1;
            stk_waddr      = '0;
            depth_nxt      = DEPTH_W'(1);
            running_nxt    = '0;
            start_pend_nxt = 1'b0;
          end
        end else begin
          clr_cnt_nxt = clr_cnt_r + TIDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          unique case (in_data.kind)
            KIND_TICK: begin
              running_nxt = sat_add(running_r, COUNT_W'(1));
            end
            KIND_ENTRY: begin
              if (depth_r == DEPTH_W'(STACK_DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: STATUS_OVERFLOW, report_lib: in_data.lib_id,
                                  report_fun: in_data.fun_id, block_total: '0};
              end else if (depth_r == '0) begin
                stk_we      = 1'b1;
                stk_wdata   = {in_data.lib_id, in_data.fun_id};
                depth_nxt   = DEPTH_W'(1);
                running_nxt = '0;
              end else begin
                stk_re    = 1'b1;
                state_nxt = S_STACK;
              end
            end
            KIND_EXIT: begin
              if (depth_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: STATUS_UNDERFLOW, report_lib: in_data.lib_id,
                                  report_fun: in_data.fun_id, block_total: '0};
              end else begin
                tbl_re    = 1'b1;
                tbl_raddr = table_index(in_data.lib_id, in_data.fun_id);
                tidx_nxt  = table_index(in_data.lib_id, in_data.fun_id);
                tin_nxt   = in_table(in_data.lib_id, in_data.fun_id);
                state_nxt = S_EXIT;
              end
            end
            KIND_START: begin
              running_nxt    = '0;
              depth_nxt      = '0;
              clr_cnt_nxt    = '0;
              start_pend_nxt = 1'b1;
              state_nxt      = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_STACK: begin
        // The caller on top of the stack is known; fetch its counter.
        tbl_re    = 1'b1;
        tbl_raddr = table_index(top_lib, top_fun);
        tidx_nxt  = table_index(top_lib, top_fun);
        tin_nxt   = in_table(top_lib, top_fun);
        state_nxt = S_TABLE;
      end
      S_TABLE: begin
        // Credit the caller, then push the entered function.
        tbl_we      = tin_r;
        tbl_wdata   = sat_add(tbl_rdata_r, running_r);
        stk_we      = 1'b1;
        depth_nxt   = depth_r + DEPTH_W'(1);
        running_nxt = '0;
        state_nxt   = S_IDLE;
      end
      S_EXIT: begin
        tbl_we        = tin_r;
        tbl_wdata     = '0;
        running_nxt   = '0;
        depth_nxt     = depth_r - DEPTH_W'(1);
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: STATUS_REPORT, report_lib: item_r.lib_id,
                          report_fun: item_r.fun_id,
                          block_total: sat_add(exit_base, running_r)};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      running_r    <= '0;
      depth_r      <= '0;
      clr_cnt_r    <= '0;
      start_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      depth_r      <= depth_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      start_pend_r <= start_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    tidx_r     <= tidx_nxt;
    tin_r      <= tin_nxt;
    out_data_r <= out_data_nxt;
  end

  // Counter table: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_r <= table_mem[tbl_raddr];
    end
  end

  // Call stack of (library, function) pairs.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stack_mem[stk_raddr];
    end
  end

endmodule
